FILE: hdl/uyvy2rgb_pkg.sv
package uyvy2rgb_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int MAX_STEP  = 64;
    localparam int ROW_LIMIT = 4096;

    localparam int DIM_W   = 13;
    localparam int STEP_W  = 7;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 12;
    localparam int PHASE_W = 6;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 13;

    // register indexes
    localparam logic [IDX_W-1:0] REG_OUTPUT_MODE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH    = 3'd1;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_HORIZONTAL_STEP = 3'd3;
    localparam logic [IDX_W-1:0] REG_VERTICAL_STEP   = 3'd4;

    localparam logic MODE_RGB  = 1'b0;
    localparam logic MODE_GRAY = 1'b1;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic              mode;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [STEP_W-1:0] hstep;
        logic [STEP_W-1:0] vstep;
    } cfg_t;

    // pixels of the current pair that survive decimation
    typedef struct packed {
        logic keep_even;
        logic keep_odd;
    } keep_t;

endpackage

FILE: hdl/uyvy2rgb_cfg.sv
module uyvy2rgb_cfg
    import uyvy2rgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    output cfg_t              cfg
);

    logic              mode_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [STEP_W-1:0] hstep_reg;
    logic [STEP_W-1:0] vstep_reg;
    logic [DIM_W-1:0]  width_even;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RGB;
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
            hstep_reg  <= STEP_W'(1);
            vstep_reg  <= STEP_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OUTPUT_MODE:     mode_reg   <= cfg_data[0];
                REG_SOURCE_WIDTH:    width_reg  <= cfg_data[DIM_W-1:0];
                REG_SOURCE_HEIGHT:   height_reg <= cfg_data[DIM_W-1:0];
                REG_HORIZONTAL_STEP: hstep_reg  <= cfg_data[STEP_W-1:0];
                REG_VERTICAL_STEP:   vstep_reg  <= cfg_data[STEP_W-1:0];
                default:             ;
            endcase
        end
    end

    function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] r;
        begin
            r = s;
            if (s == '0)
                r = STEP_W'(1);
            else if (s > STEP_W'(MAX_STEP))
                r = STEP_W'(MAX_STEP);
            return r;
        end
    endfunction

    assign width_even = {width_reg[DIM_W-1:1], 1'b0};

    always_comb
    begin
        cfg.mode  = mode_reg;
        cfg.hstep = eff_step(hstep_reg);
        cfg.vstep = eff_step(vstep_reg);

        cfg.width = width_even;
        if (width_even < DIM_W'(2))
            cfg.width = DIM_W'(2);
        else if (width_even > DIM_W'(MAX_WIDTH))
            cfg.width = DIM_W'(MAX_WIDTH);

        cfg.height = height_reg;
        if (height_reg == '0)
            cfg.height = DIM_W'(1);
        else if (height_reg > DIM_W'(ROW_LIMIT))
            cfg.height = DIM_W'(ROW_LIMIT);
    end

endmodule

FILE: hdl/uyvy2rgb_dec.sv
module uyvy2rgb_dec
    import uyvy2rgb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  cfg_t  cfg,
    output keep_t keep
);

    logic [COL_W-1:0]   col_reg,    col_next;
    logic [ROW_W-1:0]   row_reg,    row_next;
    logic [PHASE_W-1:0] cphase_reg, cphase_next;
    logic [PHASE_W-1:0] rphase_reg, rphase_next;

    logic [PHASE_W-1:0] cphase_mid;
    logic [PHASE_W-1:0] cphase_end;
    logic [DIM_W-1:0]   col_sum;
    logic [DIM_W-1:0]   row_sum;
    logic               row_hit;

    function automatic logic [PHASE_W-1:0] advance(
        input logic [PHASE_W-1:0] p,
        input logic [STEP_W-1:0]  step
    );
        logic [STEP_W-1:0] p1;
        begin
            p1 = STEP_W'(p) + STEP_W'(1);
            return (p1 >= step) ? '0 : p1[PHASE_W-1:0];
        end
    endfunction

    always_comb
    begin
        row_hit        = (rphase_reg == '0);
        keep.keep_even = row_hit && (cphase_reg == '0);
        cphase_mid     = advance(cphase_reg, cfg.hstep);
        keep.keep_odd  = row_hit && (cphase_mid == '0);
        cphase_end     = advance(cphase_mid, cfg.hstep);

        col_sum = DIM_W'(col_reg) + DIM_W'(2);
        row_sum = DIM_W'(row_reg) + DIM_W'(1);

        col_next    = col_sum[COL_W-1:0];
        cphase_next = cphase_end;
        row_next    = row_reg;
        rphase_next = rphase_reg;

        // end of line: restart column, move to next row or wrap the frame
        if (col_sum >= cfg.width)
        begin
            col_next    = '0;
            cphase_next = '0;
            if (row_sum >= cfg.height)
            begin
                row_next    = '0;
                rphase_next = '0;
            end
            else
            begin
                row_next    = row_sum[ROW_W-1:0];
                rphase_next = advance(rphase_reg, cfg.vstep);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            cphase_reg <= '0;
            rphase_reg <= '0;
        end
        else if (accept)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            cphase_reg <= cphase_next;
            rphase_reg <= rphase_next;
        end
    end

    a_col_even: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg[0] == 1'b0)
        else $error("pixel column lost even alignment");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (DIM_W'(row_reg) < DIM_W'(ROW_LIMIT)))
        else $error("row counter beyond frame limit");

    a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (col_sum >= cfg.width)) |=> (col_reg == '0 && cphase_reg == '0))
        else $error("column state not cleared at end of line");

endmodule

FILE: hdl/uyvy2rgb_csc.sv
module uyvy2rgb_csc
    import uyvy2rgb_pkg::*;
(
    input  logic       mode,
    input  logic [7:0] y,
    input  logic [7:0] u,
    input  logic [7:0] v,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    logic signed [8:0]  us;
    logic signed [8:0]  vs;
    logic signed [25:0] r_acc;
    logic signed [25:0] g_acc;
    logic signed [25:0] b_acc;
    logic signed [11:0] ys;

    function automatic logic [7:0] clamp8(input logic signed [11:0] x);
        logic [7:0] r;
        begin
            if (x < 12'sd0)
                r = 8'd0;
            else if (x > 12'sd255)
                r = 8'd255;
            else
                r = x[7:0];
            return r;
        end
    endfunction

    always_comb
    begin
        us    = $signed({1'b0, u}) - 9'sd128;
        vs    = $signed({1'b0, v}) - 9'sd128;
        ys    = $signed({4'b0000, y});
        r_acc = 26'(vs) * 26'sd18678 + 26'sd8192;
        g_acc = 26'(vs) * -26'sd9519 - 26'(us) * 26'sd6472 + 26'sd8192;
        b_acc = 26'(us) * 26'sd33292 + 26'sd8192;

        // upper bits of each sum are the floor shift by 14
        if (mode == MODE_GRAY)
        begin
            red   = 8'd0;
            green = 8'd0;
            blue  = 8'd0;
        end
        else
        begin
            red   = clamp8(ys + r_acc[25:14]);
            green = clamp8(ys + g_acc[25:14]);
            blue  = clamp8(ys + b_acc[25:14]);
        end
    end

endmodule

FILE: hdl/uyvy_to_rgb_decimating_converter.sv
// path: an accepted pair waits in the pair stage; its kept pixels are converted from
//   there into the result register, even pixel first, one result per cycle at most
// throughput: one pair per cycle if it keeps at most one pixel and the output is not
//   stalled; with both pixels kept the next pair waits until the even one moves out
// reset: rst_n clears the counters, the pending pixel flags and the output valid,
//   and returns the registers to rgb mode, 640 by 480, steps of one
module uyvy_to_rgb_decimating_converter
    import uyvy2rgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data,

    // input pair request
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        u_sample,
    input  logic [7:0]        first_luma,
    input  logic [7:0]        v_sample,
    input  logic [7:0]        second_luma,

    // result request
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue,
    output logic [7:0]        luma,
    output logic              last_of_item
);

    cfg_t  cfg;
    keep_t keep;

    logic in_accept;

    // pair stage: the accepted pair and which of its pixels still wait to go out
    logic       pend_even_reg, pend_even_next;
    logic       pend_odd_reg,  pend_odd_next;
    logic [7:0] u_reg, v_reg, y0_reg, y1_reg;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] red_reg, green_reg, blue_reg, luma_reg;
    logic       last_reg;

    logic       out_free;
    logic       emit;
    logic       emit_even;
    logic       emit_last;
    logic [7:0] sel_y;
    logic [7:0] csc_red, csc_green, csc_blue;

    uyvy2rgb_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // column/row counters decide at acceptance which pixels are kept
    uyvy2rgb_dec u_dec
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .cfg    (cfg),
        .keep   (keep)
    );

    // result register takes a new pixel when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    // even pixel always leaves first
    assign emit      = out_free && (pend_even_reg || pend_odd_reg);
    assign emit_even = pend_even_reg;
    assign emit_last = emit_even ? !pend_odd_reg : 1'b1;
    assign sel_y     = emit_even ? y0_reg : y1_reg;

    // the pair stage frees up in the cycle its final pixel moves out
    assign in_stall  = (pend_even_reg && pend_odd_reg) ||
                       ((pend_even_reg || pend_odd_reg) && !out_free);
    assign in_accept = in_valid && !in_stall;

    uyvy2rgb_csc u_csc
    (
        .mode  (cfg.mode),
        .y     (sel_y),
        .u     (u_reg),
        .v     (v_reg),
        .red   (csc_red),
        .green (csc_green),
        .blue  (csc_blue)
    );

    always_comb
    begin
        pend_even_next = pend_even_reg;
        pend_odd_next  = pend_odd_reg;
        if (emit)
        begin
            if (emit_even)
                pend_even_next = 1'b0;
            else
                pend_odd_next = 1'b0;
        end
        if (in_accept)
        begin
            pend_even_next = keep.keep_even;
            pend_odd_next  = keep.keep_odd;
        end

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_even_reg <= 1'b0;
            pend_odd_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_even_reg <= pend_even_next;
            pend_odd_reg  <= pend_odd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            u_reg  <= u_sample;
            v_reg  <= v_sample;
            y0_reg <= first_luma;
            y1_reg <= second_luma;
        end
        if (emit)
        begin
            red_reg   <= csc_red;
            green_reg <= csc_green;
            blue_reg  <= csc_blue;
            luma_reg  <= sel_y;
            last_reg  <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign luma         = luma_reg;
    assign last_of_item = last_reg;

    a_two_pending_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_even_reg && pend_odd_reg) |-> in_stall)
        else $error("new pair taken while two pixels still pending");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");

    a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cfg.mode == MODE_GRAY) |=> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
        else $error("colour channels not zero in gray mode");

    a_even_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && pend_even_reg && pend_odd_reg) |=> !last_of_item)
        else $error("even pixel flagged last while odd pixel follows");

endmodule
